>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("implication check failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("next-cycle check failed");

// a never holds
`define ASSERT_NEVER(label, clk, rst_n, a) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(a)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/eat_pkg.sv
package eat_pkg;

  localparam int EXPERT_SLOTS = 64;
  localparam int COUNT_BITS   = 48;

  localparam int IDX_W  = $clog2(EXPERT_SLOTS);
  localparam int NUM_W  = $clog2(EXPERT_SLOTS + 1);
  localparam int RANK_W = IDX_W;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int ID_W     = 6;
  localparam int TOK_W    = 16;
  localparam int TIER_W   = 2;
  localparam int OUT_CNT_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int ACT_W  = 7;
  localparam int FRAC_W = 9;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD   = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  localparam logic [TIER_W-1:0] TIER_COLD = 2'd0;
  localparam logic [TIER_W-1:0] TIER_WARM = 2'd1;
  localparam logic [TIER_W-1:0] TIER_HOT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARM   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_WR,
    ST_CLS_RDI,
    ST_CLS_LATI,
    ST_CLS_SCAN,
    ST_CLS_EMIT
  } state_t;

  // counter memory request
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    cnt_t             wr_data;
    logic             clr;
  } mem_req_t;

  // rank accumulator control
  typedef struct packed {
    logic clear;
    logic step;
  } rank_ctl_t;

endpackage

>>> rtl/core/eat_if.sv
interface eat_in_if;
  import eat_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ID_W-1:0]   slot_id;
  logic [TOK_W-1:0]  tok_in;

  modport source (output valid, op, slot_id, tok_in, input ready);
  modport sink   (input valid, op, slot_id, tok_in, output ready);
endinterface

interface eat_out_if;
  import eat_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      expert_index;
  logic [TIER_W-1:0]    tier;
  logic [OUT_CNT_W-1:0] activation_count;
  logic [OUT_CNT_W-1:0] tok_sum;
  logic                 last;

  modport source (output valid, expert_index, tier, activation_count, tok_sum, last,
                  input ready);
  modport sink   (input valid, expert_index, tier, activation_count, tok_sum, last,
                  output ready);
endinterface

>>> rtl/core/expert_activation_tiering.sv
// Channel | Dir | Word                                                   | Handshake
// in_if   | in  | op, slot_id, tok_in                                    | valid/ready
// out_if  | out | expert_index, tier, activation_count, tok_sum, last    | valid/ready
// cfg_*   | in  | cfg_index, cfg_wdata (active, hot, warm)               | cfg_we, no stall
//
// Record word: counter read, then saturating write. Clear and unused op are handled while idle.
// Classify word: per expert one counter read, then a scan of all n counters through the single
// memory read port and one comparator, plus any output stalls.
// Reset (synchronous, rst_n low) zeroes counters via valid bits at once; no clearing pass.
// in_if.ready is high only while idle; a held output word stalls the whole sequencer.
module expert_activation_tiering (
  input  logic                           clk,
  input  logic                           rst_n,
  eat_in_if.sink                         in_if,
  eat_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [eat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import eat_pkg::*;

  function automatic cnt_t sat_add(cnt_t a, logic [TOK_W-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // config registers
  logic [ACT_W-1:0]  active_r;
  logic [FRAC_W-1:0] hot_f_r;
  logic [FRAC_W-1:0] warm_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_W'(64);
      hot_f_r  <= FRAC_W'(64);
      warm_f_r <= FRAC_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE: active_r <= cfg_wdata[ACT_W-1:0];
        CFG_HOT:    hot_f_r  <= cfg_wdata;
        CFG_WARM:   warm_f_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective active count, clamped to the slot count
  logic [NUM_W-1:0] n_eff;
  assign n_eff = (8'(active_r) > 8'(EXPERT_SLOTS)) ? NUM_W'(EXPERT_SLOTS) : NUM_W'(active_r);

  // tier sizes: hot = clamp(floor(n*hot/256), 1, n); warm capped at n - hot
  logic [15:0]      hot_prod, warm_prod;
  logic [7:0]       hot_raw, warm_raw;
  logic [NUM_W-1:0] hot_sz, warm_sz, room;

  assign hot_prod  = 16'(n_eff) * 16'(hot_f_r);
  assign warm_prod = 16'(n_eff) * 16'(warm_f_r);
  assign hot_raw   = hot_prod[15:8];
  assign warm_raw  = warm_prod[15:8];

  always_comb begin
    priority if (hot_raw == 8'd0) begin
      hot_sz = NUM_W'(1);
    end else if (hot_raw > 8'(n_eff)) begin
      hot_sz = n_eff;
    end else begin
      hot_sz = NUM_W'(hot_raw);
    end
    room    = n_eff - hot_sz;
    warm_sz = (warm_raw > 8'(room)) ? room : NUM_W'(warm_raw);
  end

  // sequencer and datapath state
  state_t            state_r, state_nxt;
  logic              in_ready;
  mem_req_t          req;
  rank_ctl_t         rctl;
  cnt_t              mem_q;
  logic [RANK_W-1:0] rank_fin;

  cnt_t              total_r;
  cnt_t              ci_r;
  logic [IDX_W-1:0]  rec_id_r;
  logic [TOK_W-1:0]  tok_r;
  logic [NUM_W-1:0]  n_r, hot_r, hw_r;
  logic [IDX_W-1:0]  i_r, j_r;

  logic [ID_W-1:0]      out_idx_r;
  logic [TIER_W-1:0]    out_tier_r;
  logic [OUT_CNT_W-1:0] out_cnt_r, out_tot_r;
  logic                 out_last_r;

  op_t  in_op;
  logic rec_ok, in_take, j_last, i_last;

  assign in_op   = op_t'(in_if.op);
  assign rec_ok  = 8'(in_if.slot_id) < 8'(n_eff);
  assign in_take = in_if.valid && in_ready;
  assign j_last  = (NUM_W'(j_r) + NUM_W'(1)) == n_r;
  assign i_last  = (NUM_W'(i_r) + NUM_W'(1)) == n_r;

  eat_count_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .q     (mem_q)
  );

  eat_rank_unit u_rank (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rctl),
    .ci       (ci_r),
    .cj       (mem_q),
    .i_idx    (i_r),
    .j_idx    (j_r),
    .rank_fin (rank_fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    req       = '0;
    rctl      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          unique case (in_op)
            OP_RECORD: begin
              if (rec_ok) begin
                req.rd_en   = 1'b1;
                req.rd_addr = IDX_W'(in_if.slot_id);
                state_nxt   = ST_REC_WR;
              end
            end
            OP_CLASSIFY: begin
              if (n_eff != '0) begin
                state_nxt = ST_CLS_RDI;
              end
            end
            OP_CLEAR: req.clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_REC_WR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = rec_id_r;
        req.wr_data = sat_add(mem_q, tok_r);
        state_nxt   = ST_IDLE;
      end
      ST_CLS_RDI: begin
        req.rd_en   = 1'b1;
        req.rd_addr = i_r;
        state_nxt   = ST_CLS_LATI;
      end
      ST_CLS_LATI: begin
        // counter i arrives; start the scan at slot 0
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        rctl.clear  = 1'b1;
        state_nxt   = ST_CLS_SCAN;
      end
      ST_CLS_SCAN: begin
        rctl.step = 1'b1;
        if (j_last) begin
          state_nxt = ST_CLS_EMIT;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = j_r + IDX_W'(1);
        end
      end
      ST_CLS_EMIT: begin
        if (out_if.ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_CLS_RDI;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (req.clr) begin
      total_r <= '0;
    end else if (state_r == ST_REC_WR) begin
      total_r <= sat_add(total_r, tok_r);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      rec_id_r <= IDX_W'(in_if.slot_id);
      tok_r    <= in_if.tok_in;
      n_r      <= n_eff;
      hot_r    <= hot_sz;
      hw_r     <= hot_sz + warm_sz;
      i_r      <= '0;
    end
    if (state_r == ST_CLS_LATI) begin
      ci_r <= mem_q;
      j_r  <= '0;
    end
    if (state_r == ST_CLS_SCAN) begin
      if (!j_last) begin
        j_r <= j_r + IDX_W'(1);
      end else begin
        out_idx_r  <= ID_W'(i_r);
        out_cnt_r  <= OUT_CNT_W'(ci_r);
        out_tot_r  <= OUT_CNT_W'(total_r);
        out_last_r <= i_last;
        priority if (8'(rank_fin) < 8'(hot_r)) begin
          out_tier_r <= TIER_HOT;
        end else if (8'(rank_fin) < 8'(hw_r)) begin
          out_tier_r <= TIER_WARM;
        end else begin
          out_tier_r <= TIER_COLD;
        end
      end
    end
    if (state_r == ST_CLS_EMIT && out_if.ready && !out_last_r) begin
      i_r <= i_r + IDX_W'(1);
    end
  end

  assign in_if.ready             = in_ready;
  assign out_if.valid            = (state_r == ST_CLS_EMIT);
  assign out_if.expert_index     = out_idx_r;
  assign out_if.tier             = out_tier_r;
  assign out_if.activation_count = out_cnt_r;
  assign out_if.tok_sum          = out_tot_r;
  assign out_if.last             = out_last_r;

endmodule

>>> rtl/core/eat_count_mem.sv
module eat_count_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  eat_pkg::mem_req_t req,
  output eat_pkg::cnt_t     q
);
  import eat_pkg::*;

  cnt_t                    mem [EXPERT_SLOTS];
  logic [EXPERT_SLOTS-1:0] vld_r;
  cnt_t                    rd_q_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // valid bits stand in for the zeroed contents after reset or clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign q = rd_vld_r ? rd_q_r : '0;

endmodule

>>> rtl/core/eat_rank_unit.sv
module eat_rank_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  eat_pkg::rank_ctl_t         ctl,
  input  eat_pkg::cnt_t              ci,
  input  eat_pkg::cnt_t              cj,
  input  logic [eat_pkg::IDX_W-1:0]  i_idx,
  input  logic [eat_pkg::IDX_W-1:0]  j_idx,
  output logic [eat_pkg::RANK_W-1:0] rank_fin
);
  import eat_pkg::*;

  logic [RANK_W-1:0] rank_r;
  logic              ahead;

  // j ranks ahead of i: larger count, or equal count at a lower index
  assign ahead    = (cj > ci) || ((cj == ci) && (j_idx < i_idx));
  assign rank_fin = rank_r + RANK_W'(ahead);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else if (ctl.clear) begin
      rank_r <= '0;
    end else if (ctl.step) begin
      rank_r <= rank_fin;
    end
  end

endmodule

>>> rtl/core/eat_checker.sv
`include "assert_macros.svh"

module eat_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_last,
  input logic [eat_pkg::ID_W-1:0]      out_index,
  input logic [eat_pkg::OUT_CNT_W-1:0] out_count
);
  import eat_pkg::*;

  logic out_take;
  assign out_take = out_valid && out_ready;

  // sequencer never takes a word while a result is pending
  `ASSERT_NEVER(a_ready_vs_result, clk, rst_n, in_ready && out_valid)
  // no result in the cycle right after an input word is taken
  `ASSERT_NEXT(a_quiet_after_take, clk, rst_n, in_valid && in_ready, !out_valid)
  // more results follow inside the same classify
  `ASSERT_NEXT(a_busy_after_mid, clk, rst_n, out_take && !out_last, !in_ready)
  // final result returns the block to idle
  `ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_take && out_last, in_ready && !out_valid)
  // stalled result holds
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_index) && $stable(out_count) && $stable(out_last))

endmodule

bind expert_activation_tiering eat_checker u_eat_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_last  (out_if.last),
  .out_index (out_if.expert_index),
  .out_count (out_if.activation_count)
);

>>> bench/tb_top.sv
module tb_top;
  import eat_pkg::*;

  // Unused op code: the block must ignore it and produce no words.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Cycles with no handshake on either channel before the run is called hung.
  // The longest quiet stretch in a correct run is one expert's scan plus a receiver
  // stall run, so this is far above it.
  localparam int HANG_LIMIT = 20000;

  // Cycles to let the block go idle after the last result word.
  // A record is a read-modify-write, so this is plenty.
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [ID_W-1:0]      idx;
    logic [TIER_W-1:0]    tier;
    logic [OUT_CNT_W-1:0] count;
    logic [OUT_CNT_W-1:0] total;
    logic                 last;
  } tier_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  eat_in_if  in_if ();
  eat_out_if out_if ();

  expert_activation_tiering u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the block: counters, running total, and register copies.
  // ---------------------------------------------------------------------------
  cnt_t              act_count [EXPERT_SLOTS];
  cnt_t              tok_total;
  logic [ACT_W-1:0]  active_q;
  logic [FRAC_W-1:0] hot_q;
  logic [FRAC_W-1:0] warm_q;

  // Result words still owed by the block, oldest first.
  tier_report_t pending_reports [$];

  int fail_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  tier_report_t want;

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic cnt_t sat_sum(cnt_t a, logic [TOK_W-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + b;
    return (s > CNT_MAX) ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // Values above the slot count behave as the slot count.
  function automatic int live_experts();
    return (active_q > EXPERT_SLOTS) ? EXPERT_SLOTS : int'(active_q);
  endfunction

  task automatic reset_shadow();
    foreach (act_count[i]) act_count[i] = '0;
    tok_total = '0;
    active_q  = ACT_W'(64);
    hot_q     = FRAC_W'(64);
    warm_q    = FRAC_W'(64);
  endtask

  // Apply one accepted input word to the shadow state and queue its results.
  task automatic predict_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [TOK_W-1:0] tok);
    int n;
    int hot;
    int warm;
    int rank;
    tier_report_t r;
    n = live_experts();
    case (op)
      OP_RECORD: begin
        // ids at or above the live count are dropped
        if (int'(id) < n) begin
          act_count[id] = sat_sum(act_count[id], tok);
          tok_total     = sat_sum(tok_total, tok);
        end
      end
      OP_CLEAR: begin
        foreach (act_count[i]) act_count[i] = '0;
        tok_total = '0;
      end
      OP_CLASSIFY: begin
        if (n > 0) begin
          // Tier sizes from Q1.8 fractions: at least one hot, hot capped at n,
          // warm capped at whatever hot leaves.
          hot = (n * int'(hot_q)) >> 8;
          if (hot < 1) hot = 1;
          if (hot > n) hot = n;
          warm = (n * int'(warm_q)) >> 8;
          if (warm > n - hot) warm = n - hot;
          for (int i = 0; i < n; i++) begin
            // rank = experts with a larger count, or equal count and lower id
            rank = 0;
            for (int j = 0; j < n; j++) begin
              if (act_count[j] > act_count[i] ||
                  (act_count[j] == act_count[i] && j < i))
                rank++;
            end
            r.idx   = ID_W'(i);
            r.tier  = (rank < hot) ? TIER_HOT : (rank < hot + warm) ? TIER_WARM : TIER_COLD;
            r.count = act_count[i][OUT_CNT_W-1:0];
            r.total = tok_total[OUT_CNT_W-1:0];
            r.last  = (i == n - 1);
            pending_reports.push_back(r);
          end
        end
      end
      default: ;  // unused op: nothing happens
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driving: everything changes at the falling edge, handshakes sampled at
  // the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one word; returns at the rising edge where it was taken, with valid
  // still high so a following word can go out back to back.
  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [TOK_W-1:0] tok);
    while (coin(send_idle_pct)) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.slot_id <= id;
    in_if.tok_in  <= tok;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_word(op, id, tok);
  endtask

  // Drop valid, wait for every owed word, then let the block finish any
  // record still in flight.
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; set_config lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ACTIVE: active_q = data[ACT_W-1:0];
      CFG_HOT:    hot_q    = data[FRAC_W-1:0];
      CFG_WARM:   warm_q   = data[FRAC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int active, int hot, int warm);
    settle();
    write_reg(CFG_ACTIVE, CFG_DATA_W'(active));
    write_reg(CFG_HOT, CFG_DATA_W'(hot));
    write_reg(CFG_WARM, CFG_DATA_W'(warm));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Receiver back-pressure.
  always @(negedge clk) out_if.ready <= !coin(recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Result checking: every accepted output word against the oldest owed one.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result word for expert %0d", out_if.expert_index);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("expert_index", 64'(want.idx), 64'(out_if.expert_index));
        check_field("tier", 64'(want.tier), 64'(out_if.tier));
        check_field("activation_count", 64'(want.count), 64'(out_if.activation_count));
        check_field("tok_sum", 64'(want.total), 64'(out_if.tok_sum));
        check_field("last", 64'(want.last), 64'(out_if.last));
      end
    end
  end

  // Hang detector: any handshake on either channel resets the count.
  always @(posedge clk) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Out of reset: 64 experts, all counts zero, so ties resolve purely by id.
  // Quarter hot and quarter warm gives ids 0-15 hot, 16-31 warm.
  task automatic test_reset_state();
    send_word(OP_CLASSIFY, '0, '0);
  endtask

  // 8 experts: hot 2, warm 4. Max tokens, zero tokens, a tie at the top
  // (lower id wins), an inactive id and the unused op, both ignored.
  task automatic test_record_extremes();
    set_config(8, 64, 128);
    send_word(OP_RECORD, 6'd0, 16'hFFFF);
    send_word(OP_RECORD, 6'd7, 16'h0000);
    send_word(OP_RECORD, 6'd3, 16'hFFFF);
    send_word(OP_RECORD, 6'd5, 16'h0001);
    send_word(OP_RECORD, 6'd63, 16'hFFFF);
    send_word(OP_UNUSED, 6'd63, 16'hFFFF);
    send_word(OP_RECORD, 6'd5, 16'h0001);
    send_word(OP_CLASSIFY, 6'd0, 16'h0000);
  endtask

  task automatic test_active_limits();
    // zero experts: record dropped, classify silent
    set_config(0, 64, 64);
    send_word(OP_RECORD, 6'd1, 16'd5);
    send_word(OP_CLASSIFY, 6'd0, 16'd0);
    // count above slots acts as 64; fractions above one cap to all hot
    set_config(127, 511, 511);
    send_word(OP_RECORD, 6'd63, 16'hFFFF);
    send_word(OP_RECORD, 6'd42, 16'h5555);
    send_word(OP_RECORD, 6'd21, 16'hAAAA);
    send_word(OP_CLASSIFY, 6'd0, 16'd0);
    // zero hot fraction still yields one hot; warm takes the rest
    set_config(65, 0, 256);
    send_word(OP_CLASSIFY, 6'd0, 16'd0);
    // single expert, both fractions zero
    set_config(1, 0, 0);
    send_word(OP_RECORD, 6'd0, 16'h00FF);
    send_word(OP_CLASSIFY, 6'd0, 16'd0);
  endtask

  // Clear wipes counts and total; later records start from zero.
  task automatic test_clear();
    set_config(2, 256, 0);
    send_word(OP_RECORD, 6'd1, 16'd10);
    send_word(OP_CLEAR, 6'd0, 16'd0);
    send_word(OP_RECORD, 6'd0, 16'd3);
    send_word(OP_CLASSIFY, 6'd0, 16'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  function automatic int pick_fraction();
    case ($urandom_range(5))
      0: return 0;
      1: return 256;
      2: return 511;
      3: return $urandom_range(511);
      default: return $urandom_range(256);
    endcase
  endfunction

  // One word of a round. Mostly records on live experts with a mix of tiny
  // counts (forces ties) and full-range counts; some noise on top.
  task automatic send_random(int n, inout int counted);
    int live;
    int roll;
    logic [TOK_W-1:0] tok;
    live = (n > EXPERT_SLOTS) ? EXPERT_SLOTS : n;
    roll = $urandom_range(99);
    tok  = coin(50) ? TOK_W'($urandom_range(3)) : TOK_W'($urandom_range(65535));
    if (roll < 78 && live > 0) begin
      send_word(OP_RECORD, ID_W'($urandom_range(live - 1)), tok);
    end else if (roll < 84) begin
      // id outside the live range when there is one, otherwise anything
      if (live < EXPERT_SLOTS)
        send_word(OP_RECORD, ID_W'($urandom_range(EXPERT_SLOTS - 1, live)), tok);
      else
        send_word(OP_RECORD, ID_W'($urandom), tok);
    end else if (roll < 90) begin
      send_word(OP_UNUSED, ID_W'($urandom), TOK_W'($urandom));
    end else if (roll < 93) begin
      send_word(OP_CLEAR, ID_W'($urandom), TOK_W'($urandom));
    end else begin
      // classify mid-round, no pause in front of it
      send_word(OP_CLASSIFY, ID_W'($urandom), TOK_W'($urandom));
    end
    counted++;
  endtask

  // Four idling phases; each is a series of rounds: new settings, a burst
  // of records, then a classify. Most rounds use few experts to keep the
  // quadratic classify short; a few use the full 64 or more.
  task automatic test_random_traffic();
    int counted;
    int n;
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(57, 0);
        2: set_idling(0, 57);
        default: set_idling(9, 9);
      endcase
      counted = 0;
      while (counted < 105) begin
        pick = $urandom_range(11);
        if (pick == 0) n = $urandom_range(127, 64);
        else if (pick == 1) n = 0;
        else n = $urandom_range(12, 1);
        set_config(n, pick_fraction(), pick_fraction());
        repeat ($urandom_range(20, 4)) send_random(n, counted);
        send_word(OP_CLASSIFY, ID_W'($urandom), TOK_W'($urandom));
        counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.op      = OP_RECORD;
    in_if.slot_id = '0;
    in_if.tok_in  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ACTIVE;
    cfg_wdata     = '0;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0, 0);
    test_reset_state();
    test_record_extremes();
    test_active_limits();
    test_clear();
    test_random_traffic();

    // drain: every owed word in, then a quiet tail; the hang detector
    // bounds this wait
    settle();
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> expert_activation_tiering.f
+incdir+rtl/core
rtl/core/eat_pkg.sv
rtl/core/eat_if.sv
rtl/core/eat_count_mem.sv
rtl/core/eat_rank_unit.sv
rtl/core/expert_activation_tiering.sv
rtl/core/eat_checker.sv
bench/tb_top.sv
